/* design/sts_pkg.sv */
`default_nettype none

package sts_pkg;

  // Default table depth
  localparam int unsigned SLOTS_DEFAULT = 16;

  localparam logic [31:0] TICK_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_REGISTER = 3'd1,
    OP_DELETE   = 3'd2,
    OP_START    = 3'd3,
    OP_STOP     = 3'd4,
    OP_CHPERIOD = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_HALTED   = 2'd0,
    MODE_RUNNING  = 2'd1,
    MODE_EXECUTED = 2'd2
  } mode_e;

  // One task slot as stored in the slot RAM
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] period;
    logic [31:0] deadline;
    mode_e       mode;
    logic        rep;
  } slot_t;

endpackage

`default_nettype wire

/* design/sts_ram.sv */
`default_nettype none

module sts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* design/software_timer_task_scheduler.sv */
`default_nettype none

// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+-------------------------------------
// in      | input     | in_valid_i / in_stall_o    | opcode_i, task_id_i, periodic_i,
//         |           |                            | period_i
// out     | output    | out_valid_o / out_stall_i  | fired_o, fired_id_o, status_o,
//         |           |                            | used_slots_o
//
// Register, unused opcodes and any beat on an empty table go from S_IDLE to S_DONE without a scan.
// Tick, delete, start, stop and change period otherwise walk the used slots through the
// slot RAM's single read port, one a cycle, then go to S_DONE.
// Reset clears the registers, slot count and tick counter included, but not the slot RAM;
// slots are written at register time. A result waits in the output register while out_stall_i is high; the next
// beat is taken in the meantime, and its result waits in the sequencer.

module software_timer_task_scheduler #(
  parameter int unsigned TASK_SLOTS = sts_pkg::SLOTS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [31:0] task_id_i,
  input  wire logic        periodic_i,
  input  wire logic [31:0] period_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             fired_o,
  output logic [31:0]      fired_id_o,
  output logic [1:0]       status_o,
  output logic [4:0]       used_slots_o
);

  // AW indexes the RAM, CW holds a count up to TASK_SLOTS
  localparam int unsigned AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);
  localparam logic [CW-1:0] SlotsC = CW'(TASK_SLOTS);
  localparam int unsigned SlotW = $bits(sts_pkg::slot_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  // Latched beat
  logic [2:0]  op_q, op_d;
  logic [31:0] id_q, id_d;
  logic        rep_q, rep_d;
  logic [31:0] per_q, per_d;

  // Scheduler state
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   now_q, now_d;
  logic          wrap_q, wrap_d;

  // Scan pipeline: read address, then RAM data for idx_q in the cycle after
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          vld_q, vld_d;
  logic          found_q, found_d;

  // Pending result
  logic          res_fired_q, res_fired_d;
  logic [31:0]   res_id_q, res_id_d;
  logic [1:0]    res_status_q, res_status_d;

  // Output register
  logic          out_valid_q, out_valid_d;
  logic          fired_q, fired_d;
  logic [31:0]   fired_id_q, fired_id_d;
  logic [1:0]    status_q, status_d;
  logic [4:0]    used_q, used_d;

  // RAM port
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [SlotW-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [SlotW-1:0] ram_rdata;

  sts_pkg::slot_t rec;
  sts_pkg::slot_t wrec;
  sts_pkg::slot_t new_rec;

  logic          in_accept;
  logic [31:0]   now_inc;
  logic [31:0]   add_b;
  logic [31:0]   sum;
  logic [31:0]   dl_eff;
  logic          due;
  logic          hit;
  logic          match;
  logic [CW-1:0] idx_prev;
  logic [CW+4:0] used_ext;

  sts_ram #(
    .WIDTH (SlotW),
    .DEPTH (TASK_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign rec       = sts_pkg::slot_t'(ram_rdata);
  assign ram_raddr = rd_idx_q[AW-1:0];
  assign idx_prev  = idx_q - CW'(1);
  assign now_inc   = now_q + 32'd1;
  assign used_ext  = {5'd0, count_q};

  // Shared adder: rearm on tick, now plus new period otherwise
  assign add_b = (op_q == sts_pkg::OP_TICK) ? rec.period : per_q;
  assign sum   = now_q + add_b;

  // Counter wrap reloads each deadline with its period ahead of the due check
  assign dl_eff = wrap_q ? rec.period : rec.deadline;
  assign due    = (rec.mode == sts_pkg::MODE_RUNNING) && (dl_eff <= now_q);
  assign hit    = vld_q && !found_q && due;
  assign match  = vld_q && !found_q && (rec.id == id_q);

  always_comb begin
    new_rec          = '0;
    new_rec.id       = task_id_i;
    new_rec.mode     = sts_pkg::MODE_HALTED;
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    id_d         = id_q;
    rep_d        = rep_q;
    per_d        = per_q;
    count_d      = count_q;
    now_d        = now_q;
    wrap_d       = wrap_q;
    rd_idx_d     = rd_idx_q;
    idx_d        = idx_q;
    vld_d        = 1'b0;
    found_d      = found_q;
    res_fired_d  = res_fired_q;
    res_id_d     = res_id_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    fired_d      = fired_q;
    fired_id_d   = fired_id_q;
    status_d     = status_q;
    used_d       = used_q;

    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    wrec      = rec;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d         = opcode_i;
          id_d         = task_id_i;
          rep_d        = periodic_i;
          per_d        = period_i;
          rd_idx_d     = '0;
          found_d      = 1'b0;
          res_fired_d  = 1'b0;
          res_id_d     = '0;
          res_status_d = sts_pkg::ST_OK;
          state_d      = S_DONE;
          unique case (opcode_i)
            sts_pkg::OP_TICK: begin
              if (now_inc == sts_pkg::TICK_MAX) begin
                now_d  = '0;
                wrap_d = 1'b1;
              end else begin
                now_d  = now_inc;
                wrap_d = 1'b0;
              end
              if (count_q != '0) begin
                state_d = S_SCAN;
              end
            end
            sts_pkg::OP_REGISTER: begin
              if (count_q >= SlotsC) begin
                res_status_d = sts_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                wrec      = new_rec;
                count_d   = count_q + CW'(1);
              end
            end
            sts_pkg::OP_DELETE, sts_pkg::OP_START, sts_pkg::OP_STOP,
            sts_pkg::OP_CHPERIOD: begin
              if (count_q == '0) begin
                res_status_d = sts_pkg::ST_UNKNOWN;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
              // unused opcodes: no change, status ok
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous slot is evaluated
        if (rd_idx_q < count_q) begin
          vld_d    = 1'b1;
          idx_d    = rd_idx_q;
          rd_idx_d = rd_idx_q + CW'(1);
        end

        if (vld_q) begin
          unique case (op_q)
            sts_pkg::OP_TICK: begin
              wrec.deadline = (hit && rec.rep) ? sum : dl_eff;
              if (hit && !rec.rep) begin
                wrec.mode = sts_pkg::MODE_EXECUTED;
              end
              ram_we = wrap_q || hit;
              if (hit) begin
                found_d     = 1'b1;
                res_fired_d = 1'b1;
                res_id_d    = rec.id;
              end
            end
            sts_pkg::OP_DELETE: begin
              // after the match each later slot moves down by one
              if (found_q) begin
                ram_we    = 1'b1;
                ram_waddr = idx_prev[AW-1:0];
              end
              if (match) begin
                found_d = 1'b1;
              end
            end
            sts_pkg::OP_START: begin
              wrec.period   = per_q;
              wrec.deadline = sum;
              wrec.mode     = sts_pkg::MODE_RUNNING;
              wrec.rep      = rep_q;
              ram_we        = match;
              if (match) begin
                found_d = 1'b1;
              end
            end
            sts_pkg::OP_STOP: begin
              wrec.mode = sts_pkg::MODE_HALTED;
              ram_we    = match;
              if (match) begin
                found_d = 1'b1;
              end
            end
            sts_pkg::OP_CHPERIOD: begin
              wrec.period   = per_q;
              wrec.deadline = sum;
              ram_we        = match;
              if (match) begin
                found_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end else if (rd_idx_q >= count_q) begin
          // walk finished
          state_d = S_DONE;
          if (op_q != sts_pkg::OP_TICK) begin
            if (!found_q) begin
              res_status_d = sts_pkg::ST_UNKNOWN;
            end else if (op_q == sts_pkg::OP_DELETE) begin
              count_d = count_q - CW'(1);
            end
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          fired_d     = res_fired_q;
          fired_id_d  = res_id_q;
          status_d    = res_status_q;
          used_d      = used_ext[4:0];
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    ram_wdata = wrec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_q         <= '0;
      id_q         <= '0;
      rep_q        <= 1'b0;
      per_q        <= '0;
      count_q      <= '0;
      now_q        <= '0;
      wrap_q       <= 1'b0;
      rd_idx_q     <= '0;
      idx_q        <= '0;
      vld_q        <= 1'b0;
      found_q      <= 1'b0;
      res_fired_q  <= 1'b0;
      res_id_q     <= '0;
      res_status_q <= '0;
      out_valid_q  <= 1'b0;
      fired_q      <= 1'b0;
      fired_id_q   <= '0;
      status_q     <= '0;
      used_q       <= '0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      id_q         <= id_d;
      rep_q        <= rep_d;
      per_q        <= per_d;
      count_q      <= count_d;
      now_q        <= now_d;
      wrap_q       <= wrap_d;
      rd_idx_q     <= rd_idx_d;
      idx_q        <= idx_d;
      vld_q        <= vld_d;
      found_q      <= found_d;
      res_fired_q  <= res_fired_d;
      res_id_q     <= res_id_d;
      res_status_q <= res_status_d;
      out_valid_q  <= out_valid_d;
      fired_q      <= fired_d;
      fired_id_q   <= fired_id_d;
      status_q     <= status_d;
      used_q       <= used_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign fired_o      = fired_q;
  assign fired_id_o   = fired_id_q;
  assign status_o     = status_q;
  assign used_slots_o = used_q;

endmodule

`default_nettype wire
